[hdl/csis_pkg.sv]
// Shared types and constants for the curve slope / integral stream block.
// No dependencies; imported by csis_iter and curve_slope_integral_stream_top.
`timescale 1ns / 1ps

package csis_pkg;

    // Sample width of every x / y / result word (Q16.16 by default)
    localparam int SW = 32;
    // Width of differences and sums of two samples
    localparam int DW = SW + 1;

    typedef struct packed {
        logic signed [SW-1:0] sample_x;
        logic signed [SW-1:0] sample_y;
        logic                 sample_valid;
        logic                 first_of_curve;
    } in_word_t;

    typedef struct packed {
        logic signed [SW-1:0] mid_x;
        logic signed [SW-1:0] slope;
        logic                 slope_valid;
        logic signed [SW-1:0] running_integral;
        logic                 integral_valid;
        logic                 sign_change;
        logic signed [SW-1:0] y_minimum;
        logic signed [SW-1:0] y_maximum;
        logic                 extremes_valid;
    } out_word_t;

    // Status and results of the iterative multiply / divide unit
    typedef struct packed {
        logic              done;
        logic              ovf;
        logic [SW-2:0]     quo;
        logic [2*DW-1:0]   prod;
    } iter_res_t;

    // Magnitude of a signed DW-bit value, as unsigned DW bits
    function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
        logic [DW-1:0] r;
        r = v[DW-1] ? DW'(-v) : DW'(v);
        return r;
    endfunction

endpackage

[hdl/csis_iter.sv]
// Iterative shift-add multiplier and restoring divider, one bit per cycle.
// Depends on csis_pkg (DW, SW, iter_res_t).
`timescale 1ns / 1ps

module csis_iter
    import csis_pkg::*;
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DW-1:0]      mcand,
    input  logic [DW-1:0]      divisor,
    input  logic [DW+FRAC_BITS-1:0] dividend,
    output iter_res_t          res
);

    localparam int NW = DW + FRAC_BITS;
    localparam int CW = $clog2(DW);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [2*DW-1:0] p_reg, p_next;
    logic [DW-1:0]   a_reg, a_next;
    logic [DW-1:0]   d_reg, d_next;
    logic [DW-1:0]   r_reg, r_next;
    logic [SW-2:0]   q_reg, q_next;
    logic [SW-2:0]   n_reg, n_next;
    logic            ovf_reg, ovf_next;

    logic [DW-1:0]   top_ext;
    logic [DW:0]     hi_sum;
    logic [DW:0]     trial;
    logic [DW+1:0]   diff;
    logic            ge;

    // Upper part of the dividend; quotient overflows 31 bits iff it reaches the divisor
    assign top_ext = DW'(dividend[NW-1:SW-1]);
    assign hi_sum  = {1'b0, p_reg[2*DW-1:DW]} + (p_reg[0] ? {1'b0, a_reg} : '0);
    assign trial   = {r_reg, n_reg[SW-2]};
    assign diff    = {1'b0, trial} - {2'b00, d_reg};
    assign ge      = ~diff[DW+1];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        p_next    = p_reg;
        a_next    = a_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        q_next    = q_reg;
        n_next    = n_reg;
        ovf_next  = ovf_reg;
        if (start)
        begin
            busy_next = 1'b1;
            done_next = 1'b0;
            cnt_next  = CW'(DW-1);
            p_next    = {{DW{1'b0}}, divisor};
            a_next    = mcand;
            d_next    = divisor;
            ovf_next  = (top_ext >= divisor);
            r_next    = (top_ext >= divisor) ? '0 : top_ext;
            q_next    = '0;
            n_next    = dividend[SW-2:0];
        end
        else if (busy_reg)
        begin
            p_next = {hi_sum, p_reg[DW-1:1]};
            // divide runs over the last SW-1 of the DW multiply steps
            if (cnt_reg < CW'(SW-1))
            begin
                r_next = ge ? diff[DW-1:0] : trial[DW-1:0];
                q_next = {q_reg[SW-3:0], ge};
                n_next = {n_reg[SW-3:0], 1'b0};
            end
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg   <= p_next;
        a_reg   <= a_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
        q_reg   <= q_next;
        n_reg   <= n_next;
        ovf_reg <= ovf_next;
    end

    assign res.done = done_reg;
    assign res.ovf  = ovf_reg;
    assign res.quo  = q_reg;
    assign res.prod = p_reg;

endmodule

[hdl/curve_slope_integral_stream_top.sv]
// Curve slope / trapezoid integral stream, top level.
// Depends on csis_pkg and csis_iter.
`timescale 1ns / 1ps

// Takes curve points (x, y, valid, first-of-curve) in signed fixed point with
// FRACTION_BITS fraction bits, one word per handshake. The first point of a
// curve (or the first point after reset) only loads the previous point,
// clears the integral and restarts the y extremes from its own y; it gives no word.
// Every later point gives one output word: floor midpoint of the two x values,
// the truncated quotient dy/dx saturated to 32 bits, the running trapezoid
// integral (saturating, held across invalid pairs), a strict sign change flag
// and the running y minimum / maximum. A point that gives a word occupies the
// block from its acceptance through the iterative unit (a shift-add multiplier
// for the trapezoid area, with the restoring divider producing one quotient
// bit per cycle) until it loads the output register, waiting in S_HOLD while
// the previous word is not yet taken; in_ready is low during that time. The
// output register lets the next point be accepted while the previous word waits.
module curve_slope_integral_stream_top
    import csis_pkg::*;
#(
    parameter int FRACTION_BITS = 16
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  in_word_t  in_data,
    output logic      out_valid,
    input  logic      out_ready,
    output out_word_t out_data
);

    localparam int NW = DW + FRACTION_BITS;
    localparam logic signed [SW-1:0] SMAX = {1'b0, {(SW-1){1'b1}}};
    localparam logic signed [SW-1:0] SMIN = {1'b1, {(SW-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RUN  = 3'b010,
        S_HOLD = 3'b100
    } state_t;

    state_t state_reg, state_next;

    // curve state
    logic signed [SW-1:0] prev_x_reg, prev_x_next;
    logic signed [SW-1:0] prev_y_reg, prev_y_next;
    logic                 prev_ok_reg, prev_ok_next;
    logic                 have_prev_reg, have_prev_next;
    logic signed [SW-1:0] acc_reg, acc_next;
    logic signed [SW-1:0] least_reg, least_next;
    logic signed [SW-1:0] greatest_reg, greatest_next;
    logic                 have_ext_reg, have_ext_next;

    // per-pair operands kept while the unit runs
    logic signed [SW-1:0] mid_reg, mid_next;
    logic                 pair_ok_reg, pair_ok_next;
    logic                 slope_ok_reg, slope_ok_next;
    logic                 sc_reg, sc_next;
    logic                 slope_neg_reg, slope_neg_next;
    logic                 area_neg_reg, area_neg_next;

    out_word_t            out_reg, out_next;
    logic                 out_valid_reg, out_valid_next;

    // accept-side arithmetic
    logic                 accept;
    logic                 restart;
    logic signed [DW-1:0] sx, sy, spx, spy;
    logic signed [DW-1:0] sum_x, dx, dy, ys;
    logic                 pair_ok;
    logic                 y_pos, y_neg, py_pos, py_neg;
    logic [DW-1:0]        mag_dx, mag_dy, mag_ys;
    logic [NW-1:0]        dividend;

    // finish-side arithmetic
    iter_res_t            res;
    logic                 can_load;
    logic                 finish;
    logic signed [SW-1:0] slope_val;
    logic [SW-1:0]        quo_ext;
    logic [2*DW-1:0]      am;
    logic                 am_big;
    logic signed [DW+1:0] acc_wide, area_wide, acc_sum;
    logic signed [SW-1:0] acc_sat;
    logic signed [SW-1:0] acc_new;

    assign accept  = in_valid && in_ready;
    assign restart = in_data.first_of_curve || !have_prev_reg;

    assign sx    = DW'(in_data.sample_x);
    assign sy    = DW'(in_data.sample_y);
    assign spx   = DW'(prev_x_reg);
    assign spy   = DW'(prev_y_reg);
    assign sum_x = spx + sx;
    assign dx    = sx - spx;
    assign dy    = sy - spy;
    assign ys    = spy + sy;

    assign pair_ok = in_data.sample_valid && prev_ok_reg;
    assign y_pos   = !in_data.sample_y[SW-1] && (in_data.sample_y != '0);
    assign y_neg   = in_data.sample_y[SW-1];
    assign py_pos  = !prev_y_reg[SW-1] && (prev_y_reg != '0);
    assign py_neg  = prev_y_reg[SW-1];

    assign mag_dx   = mag(dx);
    assign mag_dy   = mag(dy);
    assign mag_ys   = mag(ys);
    assign dividend = NW'(mag_dy) << FRACTION_BITS;

    csis_iter #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_iter (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (accept && !restart),
        .mcand    (mag_ys),
        .divisor  (mag_dx),
        .dividend (dividend),
        .res      (res)
    );

    // slope: quotient fits 31 bits unless the unit flagged overflow
    assign quo_ext = SW'(res.quo);
    always_comb
    begin
        if (!slope_ok_reg)
            slope_val = '0;
        else if (res.ovf)
            slope_val = slope_neg_reg ? SMIN : SMAX;
        else
            slope_val = slope_neg_reg ? -$signed(quo_ext) : $signed(quo_ext);
    end

    // trapezoid area = |ys| * |dx| >> (F+1); anything past DW bits saturates
    assign am        = res.prod >> (FRACTION_BITS + 1);
    assign am_big    = |am[2*DW-1:DW];
    assign acc_wide  = (DW+2)'(acc_reg);
    assign area_wide = area_neg_reg ? -$signed({2'b00, am[DW-1:0]})
                                    : $signed({2'b00, am[DW-1:0]});
    assign acc_sum   = acc_wide + area_wide;

    always_comb
    begin
        if (am_big)
            acc_sat = area_neg_reg ? SMIN : SMAX;
        else if (acc_sum > (DW+2)'(SMAX))
            acc_sat = SMAX;
        else if (acc_sum < (DW+2)'(SMIN))
            acc_sat = SMIN;
        else
            acc_sat = acc_sum[SW-1:0];
    end

    assign acc_new  = pair_ok_reg ? acc_sat : acc_reg;
    assign can_load = !out_valid_reg || out_ready;
    assign finish   = ((state_reg == S_RUN) && res.done) || (state_reg == S_HOLD);

    always_comb
    begin
        state_next     = state_reg;
        prev_x_next    = prev_x_reg;
        prev_y_next    = prev_y_reg;
        prev_ok_next   = prev_ok_reg;
        have_prev_next = have_prev_reg;
        acc_next       = acc_reg;
        least_next     = least_reg;
        greatest_next  = greatest_reg;
        have_ext_next  = have_ext_reg;
        mid_next       = mid_reg;
        pair_ok_next   = pair_ok_reg;
        slope_ok_next  = slope_ok_reg;
        sc_next        = sc_reg;
        slope_neg_next = slope_neg_reg;
        area_neg_next  = area_neg_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg) inside
            S_IDLE:
            begin
                if (accept)
                begin
                    prev_x_next    = in_data.sample_x;
                    prev_y_next    = in_data.sample_y;
                    prev_ok_next   = in_data.sample_valid;
                    have_prev_next = 1'b1;
                    if (restart)
                    begin
                        // new curve: clear integral and extremes, fold this y
                        acc_next      = '0;
                        have_ext_next = in_data.sample_valid;
                        least_next    = in_data.sample_valid ? in_data.sample_y : '0;
                        greatest_next = in_data.sample_valid ? in_data.sample_y : '0;
                    end
                    else
                    begin
                        if (in_data.sample_valid)
                        begin
                            have_ext_next = 1'b1;
                            if (!have_ext_reg || (in_data.sample_y < least_reg))
                                least_next = in_data.sample_y;
                            if (!have_ext_reg || (in_data.sample_y > greatest_reg))
                                greatest_next = in_data.sample_y;
                        end
                        mid_next       = sum_x[DW-1:1];
                        pair_ok_next   = pair_ok;
                        slope_ok_next  = pair_ok && (dx != '0);
                        sc_next        = pair_ok && ((py_neg && y_pos) || (py_pos && y_neg));
                        slope_neg_next = dy[DW-1] ^ dx[DW-1];
                        area_neg_next  = ys[DW-1] ^ dx[DW-1];
                        state_next     = S_RUN;
                    end
                end
            end
            S_RUN, S_HOLD:
            begin
                if (finish)
                begin
                    if (can_load)
                    begin
                        acc_next                  = acc_new;
                        out_next.mid_x            = mid_reg;
                        out_next.slope            = slope_val;
                        out_next.slope_valid      = slope_ok_reg;
                        out_next.running_integral = acc_new;
                        out_next.integral_valid   = pair_ok_reg;
                        out_next.sign_change      = sc_reg;
                        out_next.y_minimum        = have_ext_reg ? least_reg : '0;
                        out_next.y_maximum        = have_ext_reg ? greatest_reg : '0;
                        out_next.extremes_valid   = have_ext_reg;
                        out_valid_next            = 1'b1;
                        state_next                = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_HOLD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_ok_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            acc_reg       <= '0;
            least_reg     <= '0;
            greatest_reg  <= '0;
            have_ext_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            prev_x_reg    <= prev_x_next;
            prev_y_reg    <= prev_y_next;
            prev_ok_reg   <= prev_ok_next;
            have_prev_reg <= have_prev_next;
            acc_reg       <= acc_next;
            least_reg     <= least_next;
            greatest_reg  <= greatest_next;
            have_ext_reg  <= have_ext_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mid_reg       <= mid_next;
        pair_ok_reg   <= pair_ok_next;
        slope_ok_reg  <= slope_ok_next;
        sc_reg        <= sc_next;
        slope_neg_reg <= slope_neg_next;
        area_neg_reg  <= area_neg_next;
        out_reg       <= out_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
